@@ src/rgb_pixel_blend_modes_defines.svh @@
// ---------------------------------------------------------------------------
// rgb pixel blend modes assertion macros
// shared assertion forms, clocked on clock and quiet during reset
// ---------------------------------------------------------------------------
`ifndef RGB_PIXEL_BLEND_MODES_DEFINES_SVH
`define RGB_PIXEL_BLEND_MODES_DEFINES_SVH

// property that must hold at every edge outside reset
`define RPBM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("rgb_pixel_blend_modes: check failed");

// antecedent in this cycle implies consequent in the next
`define RPBM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgb_pixel_blend_modes: sequence check failed");

`endif

@@ src/rgbpbm_pkg.sv @@
// ---------------------------------------------------------------------------
// rgbpbm_pkg
// types, mode codes and the divide-by-255 helper for the pixel blender
// ---------------------------------------------------------------------------
package rgbpbm_pkg;

   localparam int NUM_CH = 3;

   typedef logic [7:0]  chan_type;
   typedef logic [15:0] prod_type;
   typedef logic [2:0]  mode_type;

   localparam chan_type CH_MAX = 8'd255;

   localparam mode_type MODE_NORMAL   = 3'd0;
   localparam mode_type MODE_ADD      = 3'd1;
   localparam mode_type MODE_MULTIPLY = 3'd2;
   localparam mode_type MODE_SCREEN   = 3'd3;
   localparam mode_type MODE_MAX      = 3'd4;

   // floor(x / 255) for x up to 255*255, by add-and-shift
   function automatic chan_type div255(input prod_type x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
      return t[15:8];
   endfunction

endpackage

@@ src/rgb_pixel_blend_modes.sv @@
// ---------------------------------------------------------------------------
// rgb_pixel_blend_modes
// per-channel blend of a source pixel over a destination pixel by mode,
// then a fade from destination toward the blend by opacity
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | dst rgb, src rgb, mode, opacity
//  rsp_    | out       | rsp_valid/rsp_stall | out rgb
//
//  four register stages: products, mode select, opacity product, output
//  one pixel accepted every cycle when not stalled
//  the 8x8 multiplies per channel (two in stage 1, one in stage 3) set the stage split
//  synchronous reset clears only the stage valid bits
//  a stage advances whenever the one after it is empty or advancing,
//  so bubbles collapse and a stalled output still lets earlier stages fill
// ---------------------------------------------------------------------------
module rgb_pixel_blend_modes
   import rgbpbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,

   input  logic     req_valid,
   output logic     req_stall,
   input  chan_type req_dst_red,
   input  chan_type req_dst_green,
   input  chan_type req_dst_blue,
   input  chan_type req_src_red,
   input  chan_type req_src_green,
   input  chan_type req_src_blue,
   input  mode_type req_blend_mode,
   input  chan_type req_opacity,

   output logic     rsp_valid,
   input  logic     rsp_stall,
   output chan_type rsp_out_red,
   output chan_type rsp_out_green,
   output chan_type rsp_out_blue
);

   // stage 1: raw products and sum
   logic                           s1_valid_ff;
   chan_type [NUM_CH-1:0]          s1_dst_ff, s1_src_ff;
   prod_type [NUM_CH-1:0]          s1_mul_ff, s1_mul_in;
   prod_type [NUM_CH-1:0]          s1_scr_ff, s1_scr_in;
   logic     [NUM_CH-1:0][8:0]     s1_sum_ff, s1_sum_in;
   mode_type                       s1_mode_ff;
   chan_type                       s1_opac_ff;

   // stage 2: distance from destination to mixed value
   logic                           s2_valid_ff;
   chan_type [NUM_CH-1:0]          s2_dst_ff;
   chan_type [NUM_CH-1:0]          s2_diff_ff, s2_diff_in;
   logic     [NUM_CH-1:0]          s2_neg_ff, s2_neg_in;
   chan_type                       s2_opac_ff;

   // stage 3: opacity product
   logic                           s3_valid_ff;
   chan_type [NUM_CH-1:0]          s3_dst_ff;
   prod_type [NUM_CH-1:0]          s3_prod_ff, s3_prod_in;
   logic     [NUM_CH-1:0]          s3_neg_ff;

   // stage 4: output register
   logic                           out_valid_ff;
   chan_type [NUM_CH-1:0]          out_pix_ff, out_pix_in;

   chan_type [NUM_CH-1:0]          in_dst, in_src;
   chan_type [NUM_CH-1:0]          mixed;
   chan_type                       mag;

   logic en1, en2, en3, en4;
   logic pipe_full;

   assign en4 = !out_valid_ff || !rsp_stall;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_stall = !en1;
   assign pipe_full = s1_valid_ff && s2_valid_ff && s3_valid_ff && out_valid_ff;

   assign in_dst = {req_dst_blue, req_dst_green, req_dst_red};
   assign in_src = {req_src_blue, req_src_green, req_src_red};

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         s1_mul_in[c] = in_dst[c] * in_src[c];
         s1_scr_in[c] = (CH_MAX - in_dst[c]) * (CH_MAX - in_src[c]);
         s1_sum_in[c] = {1'b0, in_dst[c]} + {1'b0, in_src[c]};
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         case (s1_mode_ff)
            MODE_ADD:      mixed[c] = s1_sum_ff[c][8] ? CH_MAX : s1_sum_ff[c][7:0];
            MODE_MULTIPLY: mixed[c] = div255(s1_mul_ff[c]);
            MODE_SCREEN:   mixed[c] = CH_MAX - div255(s1_scr_ff[c]);
            MODE_MAX:      mixed[c] = (s1_dst_ff[c] > s1_src_ff[c]) ? s1_dst_ff[c]
                                                                    : s1_src_ff[c];
            default:       mixed[c] = s1_src_ff[c];
         endcase
         s2_neg_in[c]  = mixed[c] < s1_dst_ff[c];
         s2_diff_in[c] = s2_neg_in[c] ? (s1_dst_ff[c] - mixed[c])
                                      : (mixed[c] - s1_dst_ff[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         s3_prod_in[c] = s2_diff_ff[c] * s2_opac_ff;
      end
   end

   // opacity 255 needs no special case: mag then equals the full distance
   always_comb begin
      mag = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         mag           = div255(s3_prod_ff[c]);
         out_pix_in[c] = s3_neg_ff[c] ? (s3_dst_ff[c] - mag) : (s3_dst_ff[c] + mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_valid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_dst_ff  <= in_dst;
         s1_src_ff  <= in_src;
         s1_mul_ff  <= s1_mul_in;
         s1_scr_ff  <= s1_scr_in;
         s1_sum_ff  <= s1_sum_in;
         s1_mode_ff <= req_blend_mode;
         s1_opac_ff <= req_opacity;
      end
      if (en2) begin
         s2_dst_ff  <= s1_dst_ff;
         s2_diff_ff <= s2_diff_in;
         s2_neg_ff  <= s2_neg_in;
         s2_opac_ff <= s1_opac_ff;
      end
      if (en3) begin
         s3_dst_ff  <= s2_dst_ff;
         s3_prod_ff <= s3_prod_in;
         s3_neg_ff  <= s2_neg_ff;
      end
      if (en4) begin
         out_pix_ff <= out_pix_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_pix_ff[0];
   assign rsp_out_green = out_pix_ff[1];
   assign rsp_out_blue  = out_pix_ff[2];

`include "rgb_pixel_blend_modes_defines.svh"

   `RPBM_ASSERT_NEXT(a_accept_fills_s1, req_valid && !req_stall, s1_valid_ff)
   `RPBM_ASSERT_NEXT(a_s3_held_on_stall, s3_valid_ff && out_valid_ff && rsp_stall, s3_valid_ff)
   `RPBM_ASSERT(a_stall_chain, !req_stall || (pipe_full && rsp_stall))
   `RPBM_ASSERT(a_zero_mag_keeps_dst, !s3_valid_ff || |s3_prod_ff[0] || out_pix_in[0] == s3_dst_ff[0])

endmodule
